// ----- rtl/exact_fit_bump_allocator_defines.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef EXACT_FIT_BUMP_ALLOCATOR_DEFINES_SVH
`define EXACT_FIT_BUMP_ALLOCATOR_DEFINES_SVH
// property that must hold at every clock edge outside reset
`define EFBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked in the cycle after its trigger
`define EFBA_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`endif

// ----- rtl/efba_pkg.sv -----
// shared types and constants for the exact-fit bump allocator
// no dependencies
package efba_pkg;
   localparam int HEAP_BYTES_DEF   = 16384;
   localparam int ALIGN_DEF        = 8;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int FREE_ENTRIES_DEF = 64;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_REUSED   = 3'd0,
      ST_NEW      = 3'd1,
      ST_NOMEM    = 3'd2,
      ST_FREED    = 3'd3,
      ST_NULLFREE = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_SCAN_RD,
      S_SCAN,
      S_SHL_RD,
      S_SHL_WR,
      S_HDR_RD,
      S_HDR_WT,
      S_SHR_RD,
      S_SHR_WR,
      S_INSERT,
      S_OUT
   } state_type;
endpackage

// ----- rtl/exact_fit_bump_allocator.sv -----
// exact-fit bump allocator top level: free table, header store and sequencer
// depends on efba_pkg
//
// One transfer in gives one transfer out. Items are handled one at a time. An allocate scans the
// size-ordered table from the bottom through the table memory's read port. On an exact fit it
// closes the gap by moving the upper entries down. A free reads the header store, scans for its
// place and opens a gap by moving entries up. The table is a synchronous memory with one read
// and one write port. The header store is a single-port synchronous memory. Both have registered
// read data, and the header store needs no clearing pass. A new item is taken only once the
// result register is empty or its result is transferred in that cycle.
module exact_fit_bump_allocator #(
   parameter int HEAP_BYTES   = efba_pkg::HEAP_BYTES_DEF,
   parameter int ALIGN        = efba_pkg::ALIGN_DEF,
   parameter int HEADER_BYTES = efba_pkg::HEADER_BYTES_DEF,
   parameter int FREE_ENTRIES = efba_pkg::FREE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [14:0] req_request_size,
   input  logic [13:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   output logic [14:0] rsp_free_bytes
);
   localparam int HDR_DEPTH = HEAP_BYTES / ALIGN;
   localparam int HW  = (HDR_DEPTH > 1) ? $clog2(HDR_DEPTH) : 1;
   localparam int TW  = $clog2(FREE_ENTRIES);
   localparam int CW  = $clog2(FREE_ENTRIES + 1);
   localparam int AW  = $clog2(ALIGN) > 0 ? $clog2(ALIGN) : 1;
   localparam int OW  = $clog2(HEAP_BYTES + 1) + 1;
   localparam longint LIMIT = longint'(HEAP_BYTES) - longint'(ALIGN);
   localparam longint INIT_FREE = (LIMIT > 32767) ? 32767 : LIMIT;

   // memories
   logic [13:0] tab_addr_mem [FREE_ENTRIES];
   logic [14:0] tab_size_mem [FREE_ENTRIES];
   logic [14:0] hdr_mem      [HDR_DEPTH];

   logic          tab_we;
   logic [TW-1:0] tab_waddr, tab_raddr;
   logic [13:0]   tab_wa;
   logic [14:0]   tab_ws;
   logic [13:0]   tab_rd_a;
   logic [14:0]   tab_rd_s;
   logic          hdr_we;
   logic [HW-1:0] hdr_idx;
   logic [14:0]   hdr_wd, hdr_rd;

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_addr_mem[tab_waddr] <= tab_wa;
         tab_size_mem[tab_waddr] <= tab_ws;
      end
      tab_rd_a <= tab_addr_mem[tab_raddr];
      tab_rd_s <= tab_size_mem[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (hdr_we) hdr_mem[hdr_idx] <= hdr_wd;
      hdr_rd <= hdr_mem[hdr_idx];
   end

   // control and payload registers
   efba_pkg::state_type state_ff, state_in;
   logic          op_ff, op_in;
   logic [14:0]   size_ff, size_in;
   logic [15:0]   want_ff, want_in;
   logic [13:0]   addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [OW-1:0] bump_ff, bump_in;
   logic [14:0]   fb_ff, fb_in;
   logic          hdr_ok_ff, hdr_ok_in;
   logic          rv_ff, rv_in;
   logic [13:0]   ra_ff, ra_in;
   logic [2:0]    rs_ff, rs_in;
   logic [14:0]   rf_ff, rf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efba_pkg::S_IDLE;
         cnt_ff   <= '0;
         bump_ff  <= '0;
         fb_ff    <= 15'(INIT_FREE);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bump_ff  <= bump_in;
         fb_ff    <= fb_in;
         rv_ff    <= rv_in;
      end
      op_ff     <= op_in;
      size_ff   <= size_in;
      want_ff   <= want_in;
      addr_ff   <= addr_in;
      ptr_ff    <= ptr_in;
      hdr_ok_ff <= hdr_ok_in;
      ra_ff     <= ra_in;
      rs_ff     <= rs_in;
      rf_ff     <= rf_in;
   end

   logic [15:0] rnd;
   logic [AW-1:0] rem;
   logic [OW+1:0] bump_end;
   logic [OW:0]   data_off;
   logic [16:0]   fb_add;
   logic signed [17:0] fb_sub;
   logic [CW-1:0] ptr_p1, ptr_m1;
   logic out_free;

   assign ptr_p1 = ptr_ff + CW'(1);
   assign ptr_m1 = ptr_ff - CW'(1);
   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      if (ALIGN > 1) rem = AW'(size_ff % ALIGN);
      else rem = '0;
      if (rem != '0) rnd = {1'b0, size_ff} + 16'(ALIGN) - 16'(rem);
      else rnd = {1'b0, size_ff};
      bump_end = (OW+2)'(bump_ff) + (OW+2)'(want_ff) + (OW+2)'(HEADER_BYTES);
      data_off = (OW+1)'(bump_ff) + (OW+1)'(HEADER_BYTES);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      size_in   = size_ff;
      want_in   = want_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      bump_in   = bump_ff;
      fb_in     = fb_ff;
      hdr_ok_in = hdr_ok_ff;
      rv_in     = rv_ff;
      ra_in     = ra_ff;
      rs_in     = rs_ff;
      rf_in     = rf_ff;
      req_ready = 1'b0;
      tab_we    = 1'b0;
      tab_waddr = ptr_ff[TW-1:0];
      tab_raddr = ptr_ff[TW-1:0];
      tab_wa    = tab_rd_a;
      tab_ws    = tab_rd_s;
      hdr_we    = 1'b0;
      hdr_idx   = HW'(addr_ff / ALIGN);
      hdr_wd    = want_ff[14:0];
      fb_add    = {2'b0, fb_ff} + {2'b0, want_ff[14:0]};
      fb_sub    = 18'(signed'({3'b0, fb_ff})) - 18'(signed'({2'b0, want_ff}));
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         efba_pkg::S_IDLE: begin
            // result fields are staged in the output register, so wait until it drains
            req_ready = out_free;
            if (req_valid && out_free) begin
               op_in   = req_opcode;
               size_in = req_request_size;
               addr_in = req_block_address;
               ptr_in  = '0;
               if (req_opcode == efba_pkg::OP_ALLOC) begin
                  state_in = efba_pkg::S_ROUND;
               end else if (req_block_address == '0) begin
                  ra_in = '0; rs_in = efba_pkg::ST_NULLFREE; state_in = efba_pkg::S_OUT;
               end else if (cnt_ff >= CW'(FREE_ENTRIES)) begin
                  ra_in = '0; rs_in = efba_pkg::ST_FULL; state_in = efba_pkg::S_OUT;
               end else begin
                  hdr_ok_in = (32'(req_block_address) / ALIGN) < HDR_DEPTH;
                  state_in  = efba_pkg::S_HDR_RD;
               end
            end
         end
         efba_pkg::S_ROUND: begin
            want_in  = rnd;
            state_in = efba_pkg::S_SCAN_RD;
         end
         efba_pkg::S_HDR_RD: begin
            state_in = efba_pkg::S_HDR_WT;
         end
         efba_pkg::S_HDR_WT: begin
            want_in  = hdr_ok_ff ? {1'b0, hdr_rd} : '0;
            state_in = efba_pkg::S_SCAN_RD;
         end
         efba_pkg::S_SCAN_RD: begin
            // table entry at ptr is read this cycle
            if (ptr_ff >= cnt_ff) begin
               if (op_ff == efba_pkg::OP_FREE) begin
                  ptr_in   = cnt_ff;
                  state_in = efba_pkg::S_INSERT;
               end else if (64'(bump_end) < 64'(LIMIT)) begin
                  hdr_idx = HW'(data_off / ALIGN);
                  hdr_we  = (64'(data_off) / ALIGN) < HDR_DEPTH;
                  bump_in = OW'(bump_end);
                  fb_sub  = 18'(signed'({3'b0, fb_ff})) - 18'(signed'({2'b0, want_ff}))
                            - 18'(HEADER_BYTES);
                  fb_in   = (fb_sub < 0) ? '0 : 15'(fb_sub);
                  ra_in   = 14'(data_off);
                  rs_in   = efba_pkg::ST_NEW;
                  state_in = efba_pkg::S_OUT;
               end else begin
                  ra_in = '0; rs_in = efba_pkg::ST_NOMEM; state_in = efba_pkg::S_OUT;
               end
            end else begin
               state_in = efba_pkg::S_SCAN;
            end
         end
         efba_pkg::S_SCAN: begin
            if (op_ff == efba_pkg::OP_FREE) begin
               if ({1'b0, tab_rd_s} < want_ff) begin
                  ptr_in = ptr_p1; state_in = efba_pkg::S_SCAN_RD;
               end else begin
                  // open a gap from the top down to ptr
                  addr_in  = addr_ff;
                  size_in  = 15'(ptr_ff);
                  ptr_in   = cnt_ff;
                  state_in = efba_pkg::S_SHR_RD;
               end
            end else if ({1'b0, tab_rd_s} == want_ff) begin
               ra_in  = tab_rd_a;
               rs_in  = efba_pkg::ST_REUSED;
               fb_sub = 18'(signed'({3'b0, fb_ff})) - 18'(signed'({3'b0, tab_rd_s}));
               fb_in  = (fb_sub < 0) ? '0 : 15'(fb_sub);
               state_in = efba_pkg::S_SHL_RD;
            end else if ({1'b0, tab_rd_s} < want_ff) begin
               ptr_in = ptr_p1; state_in = efba_pkg::S_SCAN_RD;
            end else begin
               ptr_in = cnt_ff; state_in = efba_pkg::S_SCAN_RD;
            end
         end
         efba_pkg::S_SHL_RD: begin
            // read entry ptr+1 to move it into ptr
            tab_raddr = ptr_p1[TW-1:0];
            if (ptr_p1 >= cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = efba_pkg::S_OUT;
            end else begin
               state_in = efba_pkg::S_SHL_WR;
            end
         end
         efba_pkg::S_SHL_WR: begin
            tab_we   = 1'b1;
            ptr_in   = ptr_p1;
            state_in = efba_pkg::S_SHL_RD;
         end
         efba_pkg::S_SHR_RD: begin
            // ptr walks down from count; size_ff holds the insert position
            if (ptr_ff <= CW'(size_ff)) begin
               state_in = efba_pkg::S_INSERT;
            end else begin
               tab_raddr = ptr_m1[TW-1:0];
               state_in  = efba_pkg::S_SHR_WR;
            end
         end
         efba_pkg::S_SHR_WR: begin
            tab_we   = 1'b1;
            ptr_in   = ptr_m1;
            state_in = efba_pkg::S_SHR_RD;
         end
         efba_pkg::S_INSERT: begin
            tab_we   = 1'b1;
            tab_wa   = addr_ff;
            tab_ws   = want_ff[14:0];
            cnt_in   = cnt_ff + CW'(1);
            fb_in    = (fb_add > 17'd32767) ? 15'd32767 : fb_add[14:0];
            ra_in    = '0;
            rs_in    = efba_pkg::ST_FREED;
            state_in = efba_pkg::S_OUT;
         end
         efba_pkg::S_OUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rf_in    = fb_ff;
               state_in = efba_pkg::S_IDLE;
            end
         end
         default: state_in = efba_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid          = rv_ff;
   assign rsp_result_address = ra_ff;
   assign rsp_status         = rs_ff;
   assign rsp_free_bytes     = rf_ff;
endmodule

// ----- rtl/efba_checker.sv -----
// port-level checker for the exact-fit bump allocator, bound to the top level
// depends on exact_fit_bump_allocator_defines.svh and efba_pkg
`include "exact_fit_bump_allocator_defines.svh"
module efba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [13:0] rsp_result_address,
   input logic [2:0]  rsp_status
);
   logic st_nonaddr;
   assign st_nonaddr = rsp_status == efba_pkg::ST_FREED || rsp_status == efba_pkg::ST_NULLFREE
                       || rsp_status == efba_pkg::ST_FULL || rsp_status == efba_pkg::ST_NOMEM;

   `EFBA_ASSERT(a_status_range, clock, reset, !rsp_valid || rsp_status <= efba_pkg::ST_FULL, "status code out of range")
   `EFBA_ASSERT(a_zero_addr, clock, reset, !rsp_valid || !st_nonaddr || rsp_result_address == '0, "address on non-allocating result")
   `EFBA_ASSERT_NEXT(a_no_take_busy, clock, reset, req_valid && req_ready, !req_ready, "second transfer taken while busy")
   `EFBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped while stalled")
endmodule

bind exact_fit_bump_allocator efba_checker u_efba_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_address(rsp_result_address), .rsp_status(rsp_status)
);
